// ===== rtl/core/wsf_pkg.sv =====
// Package with the shared constants, types and neighbour table of the Wigner-Seitz fold block.
package wsf_pkg;

    // Sizes of the block.
    localparam int NEIGHBOUR_COUNT = 13;
    localparam int MAX_PASSES      = 64;
    localparam int COORD_BITS      = 24;

    // Fixed widths of the lattice and derived quantities.
    localparam int LAT_BITS  = 21;
    localparam int LREG_BITS = 3 * LAT_BITS;
    localparam int NB_BITS   = LAT_BITS + 2;
    localparam int J_BITS    = 4;
    localparam int H_BITS    = 48;

    // Widths that follow from the coordinate width.
    localparam int K_BITS    = COORD_BITS + 2;
    localparam int A_BITS    = K_BITS + 1;
    localparam int P_BITS    = A_BITS + NB_BITS;
    localparam int DOT_BITS  = COORD_BITS + NB_BITS + 1;
    localparam int D_BITS    = DOT_BITS + 1;
    localparam int NUM_BITS  = D_BITS + 1;
    localparam int DEN_BITS  = H_BITS + 1;
    localparam int PASS_BITS = $clog2(MAX_PASSES + 1);

    // APB register map.
    localparam int ADDR_BITS = 5;
    localparam int DATA_BITS = 64;
    localparam logic [1:0] REG_LATTICE_0 = 2'd0;
    localparam logic [1:0] REG_LATTICE_1 = 2'd1;
    localparam logic [1:0] REG_LATTICE_2 = 2'd2;

    typedef logic [2:0][LREG_BITS-1:0] lat_arr_t;
    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [NB_BITS-1:0] nb_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_ADJ,
        ST_DONE
    } state_t;

    // Lattice coefficients of each neighbour; unused rows are zero.
    localparam logic signed [1:0] COMBO [0:15][0:2] = '{
        '{ 2'sd1,  2'sd0,  2'sd0}, '{ 2'sd0,  2'sd1,  2'sd0}, '{ 2'sd0,  2'sd0,  2'sd1},
        '{ 2'sd1,  2'sd1,  2'sd0}, '{ 2'sd1, -2'sd1,  2'sd0}, '{ 2'sd0,  2'sd1,  2'sd1},
        '{ 2'sd0,  2'sd1, -2'sd1}, '{ 2'sd1,  2'sd0,  2'sd1}, '{-2'sd1,  2'sd0,  2'sd1},
        '{ 2'sd1,  2'sd1,  2'sd1}, '{ 2'sd1, -2'sd1, -2'sd1}, '{ 2'sd1,  2'sd1, -2'sd1},
        '{ 2'sd1, -2'sd1,  2'sd1}, '{ 2'sd0,  2'sd0,  2'sd0}, '{ 2'sd0,  2'sd0,  2'sd0},
        '{ 2'sd0,  2'sd0,  2'sd0}
    };

    // One component of neighbour j, formed from the three lattice vectors.
    function automatic nb_t nb_comp(input lat_arr_t lat, input logic [J_BITS-1:0] j,
                                    input logic [1:0] c);
        nb_t acc;
        logic signed [LAT_BITS-1:0] a;
        acc = '0;
        for (int i = 0; i < 3; i++) begin
            case (c)
                2'd0:    a = lat[i][LAT_BITS-1:0];
                2'd1:    a = lat[i][2*LAT_BITS-1:LAT_BITS];
                default: a = lat[i][3*LAT_BITS-1:2*LAT_BITS];
            endcase
            if (COMBO[j][i] == 2'sd1) begin
                acc = acc + nb_t'(a);
            end else if (COMBO[j][i] == -2'sd1) begin
                acc = acc - nb_t'(a);
            end
        end
        return acc;
    endfunction

endpackage

// ===== rtl/core/wsf_if.sv =====
// Valid/ready channel interfaces for input vectors and fold results.
interface wsf_in_if;
    logic                     valid;
    logic                     ready;
    logic                     operation;
    wsf_pkg::coord_t          vec_x;
    wsf_pkg::coord_t          vec_y;
    wsf_pkg::coord_t          vec_z;

    modport source (output valid, operation, vec_x, vec_y, vec_z, input ready);
    modport sink   (input valid, operation, vec_x, vec_y, vec_z, output ready);
endinterface

interface wsf_out_if;
    logic                     valid;
    logic                     ready;
    wsf_pkg::coord_t          out_x;
    wsf_pkg::coord_t          out_y;
    wsf_pkg::coord_t          out_z;
    logic                     was_inside;
    logic                     gave_up;

    modport source (output valid, out_x, out_y, out_z, was_inside, gave_up, input ready);
    modport sink   (input valid, out_x, out_y, out_z, was_inside, gave_up, output ready);
endinterface

// ===== rtl/core/wsf_cfg_regs.sv =====
// APB register file holding the three lattice vectors.
module wsf_cfg_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [wsf_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [wsf_pkg::DATA_BITS-1:0]   pwdata,
    output logic [wsf_pkg::DATA_BITS-1:0]   prdata,
    output logic                            pready,
    output wsf_pkg::lat_arr_t               lat
);

    wsf_pkg::lat_arr_t lat_reg;
    logic [1:0]        idx;

    assign idx    = paddr[4:3];
    assign pready = 1'b1;
    assign lat    = lat_reg;

    // Register write on the access phase of a transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (idx)
                wsf_pkg::REG_LATTICE_0: lat_reg[0] <= pwdata[wsf_pkg::LREG_BITS-1:0];
                wsf_pkg::REG_LATTICE_1: lat_reg[1] <= pwdata[wsf_pkg::LREG_BITS-1:0];
                wsf_pkg::REG_LATTICE_2: lat_reg[2] <= pwdata[wsf_pkg::LREG_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Read data.
    always_comb
    begin
        case (idx)
            wsf_pkg::REG_LATTICE_0: prdata = {1'b0, lat_reg[0]};
            wsf_pkg::REG_LATTICE_1: prdata = {1'b0, lat_reg[1]};
            wsf_pkg::REG_LATTICE_2: prdata = {1'b0, lat_reg[2]};
            default:                prdata = '0;
        endcase
    end

endmodule

// ===== rtl/core/wsf_mult.sv =====
// Shared signed multiplier with a registered product.
module wsf_mult
(
    input  logic                                 clk,
    input  logic signed [wsf_pkg::A_BITS-1:0]    a,
    input  wsf_pkg::nb_t                         b,
    output logic signed [wsf_pkg::P_BITS-1:0]    prod
);

    logic signed [wsf_pkg::P_BITS-1:0] prod_reg;

    assign prod = prod_reg;

    // One product per cycle.
    always_ff @(posedge clk)
    begin
        prod_reg <= wsf_pkg::P_BITS'(a) * wsf_pkg::P_BITS'(b);
    end

endmodule

// ===== rtl/core/wsf_divider.sv =====
// Restoring divider, one quotient bit per cycle.
module wsf_divider
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [wsf_pkg::NUM_BITS-1:0]      num,
    input  logic [wsf_pkg::DEN_BITS-1:0]      den,
    output logic                              done,
    output logic [wsf_pkg::NUM_BITS-1:0]      quot
);

    localparam int CNT_BITS = $clog2(wsf_pkg::NUM_BITS + 1);

    logic [wsf_pkg::DEN_BITS:0]     rem_reg, rem_next;
    logic [wsf_pkg::NUM_BITS-1:0]   q_reg, q_next;
    logic [wsf_pkg::DEN_BITS-1:0]   den_reg, den_next;
    logic [CNT_BITS-1:0]            cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [wsf_pkg::DEN_BITS:0]     shifted;

    assign done = done_reg;
    assign quot = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            q_reg    <= '0;
            den_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            rem_reg  <= rem_next;
            q_reg    <= q_next;
            den_reg  <= den_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Shift in one numerator bit and subtract when the divisor fits.
    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[wsf_pkg::DEN_BITS-1:0], q_reg[wsf_pkg::NUM_BITS-1]};
        if (start)
        begin
            rem_next  = '0;
            q_next    = num;
            den_next  = den;
            cnt_next  = CNT_BITS'(wsf_pkg::NUM_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next = shifted - {1'b0, den_reg};
                q_next   = {q_reg[wsf_pkg::NUM_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                q_next   = {q_reg[wsf_pkg::NUM_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/wigner_seitz_fold_core.sv =====
// Top level of the Wigner-Seitz cell test and fold engine.
// The block takes one vector at a time and returns it, tested against the
// Wigner-Seitz cell of the lattice held in three APB registers (byte address
// 0, 8 and 16), or folded into that cell. All arithmetic runs through one
// shared multiplier under a sequencer: for each neighbour it forms three
// squares for its half norm and three products for the dot product. The
// membership check scans every neighbour, a fold scan then runs up to the
// first neighbour that needs it, and every adjustment runs the serial divider
// (one quotient bit per cycle) and then the multiply-and-saturate of the
// three coordinates. A fold item ends when a scan needs no adjustment or
// when it hits the pass cap of MAX_PASSES adjusting passes.
// The block is not ready while an item is in work or its result waits.
module wigner_seitz_fold_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [wsf_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [wsf_pkg::DATA_BITS-1:0]   pwdata,
    output logic [wsf_pkg::DATA_BITS-1:0]   prdata,
    output logic                            pready,
    wsf_in_if.sink                          in_ch,
    wsf_out_if.source                       out_ch
);

    localparam int CB = wsf_pkg::COORD_BITS;
    localparam logic [wsf_pkg::J_BITS-1:0] J_LAST =
        wsf_pkg::J_BITS'(wsf_pkg::NEIGHBOUR_COUNT - 1);
    localparam logic [wsf_pkg::NUM_BITS-1:0] K_MAX =
        wsf_pkg::NUM_BITS'(1) << (CB + 1);
    localparam logic signed [wsf_pkg::P_BITS:0] C_MAX =
        (wsf_pkg::P_BITS + 1)'((64'sd1 <<< (CB - 1)) - 64'sd1);
    localparam logic signed [wsf_pkg::P_BITS:0] C_MIN =
        (wsf_pkg::P_BITS + 1)'(-(64'sd1 <<< (CB - 1)));

    wsf_pkg::lat_arr_t lat;

    wsf_pkg::state_t                      state_reg, state_next;
    logic [2:0]                           phase_reg, phase_next;
    logic [wsf_pkg::J_BITS-1:0]           j_reg, j_next;
    logic [wsf_pkg::PASS_BITS-1:0]        pass_reg, pass_next;
    logic                                 check_reg, check_next;
    logic                                 fold_reg, fold_next;
    logic                                 inside_reg, inside_next;
    logic                                 gave_up_reg, gave_up_next;
    logic                                 sub_reg, sub_next;
    wsf_pkg::coord_t                      v_reg [3];
    wsf_pkg::coord_t                      v_next [3];
    logic [wsf_pkg::H_BITS-1:0]           h_reg, h_next;
    logic signed [wsf_pkg::DOT_BITS-1:0]  d_reg, d_next;
    logic [wsf_pkg::K_BITS-1:0]           k_reg, k_next;

    logic [1:0]                           cidx;
    wsf_pkg::nb_t                         ncomp;
    logic signed [wsf_pkg::A_BITS-1:0]    mult_a;
    logic signed [wsf_pkg::P_BITS-1:0]    prod;
    logic                                 div_start;
    logic [wsf_pkg::NUM_BITS-1:0]         div_num;
    logic [wsf_pkg::DEN_BITS-1:0]         div_den;
    logic                                 div_done;
    logic [wsf_pkg::NUM_BITS-1:0]         div_quot;
    logic signed [wsf_pkg::D_BITS-1:0]    dd;
    logic signed [wsf_pkg::D_BITS-1:0]    hh;
    logic                                 over;
    logic                                 under;
    logic signed [wsf_pkg::NUM_BITS-1:0]  num_s;
    logic signed [wsf_pkg::P_BITS:0]      upd;

    wsf_cfg_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .lat     (lat)
    );

    wsf_mult u_mult
    (
        .clk  (clk),
        .a    (mult_a),
        .b    (ncomp),
        .prod (prod)
    );

    wsf_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Channel outputs come straight from the work registers.
    assign in_ch.ready       = (state_reg == wsf_pkg::ST_IDLE);
    assign out_ch.valid      = (state_reg == wsf_pkg::ST_DONE);
    assign out_ch.out_x      = v_reg[0];
    assign out_ch.out_y      = v_reg[1];
    assign out_ch.out_z      = v_reg[2];
    assign out_ch.was_inside = inside_reg;
    assign out_ch.gave_up    = gave_up_reg;

    // Component select and shared multiplier operands.
    always_comb
    begin
        if (state_reg == wsf_pkg::ST_SCAN && phase_reg >= 3'd3)
        begin
            cidx = phase_reg[1:0] - 2'd3;
        end
        else if (phase_reg[1:0] == 2'd3)
        begin
            cidx = 2'd0;
        end
        else
        begin
            cidx = phase_reg[1:0];
        end
        ncomp = wsf_pkg::nb_comp(lat, j_reg, cidx);
        if (state_reg == wsf_pkg::ST_ADJ)
        begin
            mult_a = signed'({1'b0, k_reg});
        end
        else if (phase_reg >= 3'd3)
        begin
            mult_a = wsf_pkg::A_BITS'(v_reg[cidx]);
        end
        else
        begin
            mult_a = wsf_pkg::A_BITS'(ncomp);
        end
    end

    // Comparison of the doubled projection with the half norm.
    always_comb
    begin
        dd    = {d_reg, 1'b0};
        hh    = signed'(wsf_pkg::D_BITS'(h_reg));
        over  = dd > hh;
        under = dd < -hh;
        if (over)
        begin
            num_s = wsf_pkg::NUM_BITS'(dd) + wsf_pkg::NUM_BITS'(hh) - 1;
        end
        else
        begin
            num_s = wsf_pkg::NUM_BITS'(hh) - wsf_pkg::NUM_BITS'(dd) - 1;
        end
        div_num = num_s;
        div_den = {h_reg, 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= wsf_pkg::ST_IDLE;
            phase_reg   <= '0;
            j_reg       <= '0;
            pass_reg    <= '0;
            check_reg   <= 1'b0;
            fold_reg    <= 1'b0;
            inside_reg  <= 1'b0;
            gave_up_reg <= 1'b0;
            sub_reg     <= 1'b0;
            v_reg       <= '{default: '0};
            h_reg       <= '0;
            d_reg       <= '0;
            k_reg       <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            j_reg       <= j_next;
            pass_reg    <= pass_next;
            check_reg   <= check_next;
            fold_reg    <= fold_next;
            inside_reg  <= inside_next;
            gave_up_reg <= gave_up_next;
            sub_reg     <= sub_next;
            v_reg       <= v_next;
            h_reg       <= h_next;
            d_reg       <= d_next;
            k_reg       <= k_next;
        end
    end

    // Sequencer: membership scan, then fold passes with divide and adjust.
    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        j_next       = j_reg;
        pass_next    = pass_reg;
        check_next   = check_reg;
        fold_next    = fold_reg;
        inside_next  = inside_reg;
        gave_up_next = gave_up_reg;
        sub_next     = sub_reg;
        v_next       = v_reg;
        h_next       = h_reg;
        d_next       = d_reg;
        k_next       = k_reg;
        div_start    = 1'b0;
        upd          = '0;

        case (state_reg)
            wsf_pkg::ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    v_next[0]    = in_ch.vec_x;
                    v_next[1]    = in_ch.vec_y;
                    v_next[2]    = in_ch.vec_z;
                    fold_next    = in_ch.operation;
                    check_next   = 1'b1;
                    inside_next  = 1'b1;
                    gave_up_next = 1'b0;
                    j_next       = '0;
                    phase_next   = '0;
                    state_next   = wsf_pkg::ST_SCAN;
                end
            end

            wsf_pkg::ST_SCAN:
            begin
                phase_next = phase_reg + 3'd1;
                if (phase_reg == 3'd0)
                begin
                    h_next = '0;
                    d_next = '0;
                end
                else if (phase_reg <= 3'd3)
                begin
                    h_next = h_reg + prod[wsf_pkg::H_BITS-1:0];
                end
                else if (phase_reg <= 3'd6)
                begin
                    d_next = d_reg + prod[wsf_pkg::DOT_BITS-1:0];
                end
                else
                begin
                    phase_next = '0;
                    if (check_reg)
                    begin
                        if (over || under)
                        begin
                            inside_next = 1'b0;
                        end
                        if (j_reg == J_LAST)
                        begin
                            j_next = '0;
                            if (fold_reg)
                            begin
                                check_next = 1'b0;
                                pass_next  = '0;
                            end
                            else
                            begin
                                state_next = wsf_pkg::ST_DONE;
                            end
                        end
                        else
                        begin
                            j_next = j_reg + 1'b1;
                        end
                    end
                    else if (h_reg != '0 && (over || under))
                    begin
                        sub_next   = over;
                        div_start  = 1'b1;
                        state_next = wsf_pkg::ST_DIV;
                    end
                    else if (j_reg == J_LAST)
                    begin
                        state_next = wsf_pkg::ST_DONE;
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
            end

            wsf_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    // Any larger count saturates every nonzero component anyway.
                    if (div_quot > K_MAX)
                    begin
                        k_next = K_MAX[wsf_pkg::K_BITS-1:0];
                    end
                    else
                    begin
                        k_next = div_quot[wsf_pkg::K_BITS-1:0];
                    end
                    phase_next = '0;
                    state_next = wsf_pkg::ST_ADJ;
                end
            end

            wsf_pkg::ST_ADJ:
            begin
                phase_next = phase_reg + 3'd1;
                if (phase_reg != 3'd0)
                begin
                    if (sub_reg)
                    begin
                        upd = (wsf_pkg::P_BITS + 1)'(v_reg[phase_reg[1:0] - 2'd1])
                            - (wsf_pkg::P_BITS + 1)'(prod);
                    end
                    else
                    begin
                        upd = (wsf_pkg::P_BITS + 1)'(v_reg[phase_reg[1:0] - 2'd1])
                            + (wsf_pkg::P_BITS + 1)'(prod);
                    end
                    if (upd > C_MAX)
                    begin
                        v_next[phase_reg[1:0] - 2'd1] = C_MAX[CB-1:0];
                    end
                    else if (upd < C_MIN)
                    begin
                        v_next[phase_reg[1:0] - 2'd1] = C_MIN[CB-1:0];
                    end
                    else
                    begin
                        v_next[phase_reg[1:0] - 2'd1] = upd[CB-1:0];
                    end
                end
                if (phase_reg == 3'd3)
                begin
                    phase_next = '0;
                    j_next     = '0;
                    pass_next  = pass_reg + 1'b1;
                    if (pass_reg == wsf_pkg::PASS_BITS'(wsf_pkg::MAX_PASSES - 1))
                    begin
                        gave_up_next = 1'b1;
                        state_next   = wsf_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = wsf_pkg::ST_SCAN;
                    end
                end
            end

            wsf_pkg::ST_DONE:
            begin
                if (out_ch.ready)
                begin
                    state_next = wsf_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = wsf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== test/wigner_seitz_fold_core_tb.sv =====
// Self-checking testbench for the Wigner-Seitz cell test and fold block.
`timescale 1ns / 1ps

module wigner_seitz_fold_core_tb;

    localparam logic OP_TEST = 1'b0;
    localparam logic OP_FOLD = 1'b1;
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam longint COORD_MAX = (longint'(1) <<< (wsf_pkg::COORD_BITS - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;
    localparam longint LAT_MAX = (longint'(1) <<< (wsf_pkg::LAT_BITS - 1)) - 1;
    localparam longint LAT_MIN = -LAT_MAX - 1;
    localparam int IDLE_LIMIT = 100000;

    typedef struct packed {
        wsf_pkg::coord_t x;
        wsf_pkg::coord_t y;
        wsf_pkg::coord_t z;
        logic   in_cell;
        logic   gave_up;
    } fold_res_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [wsf_pkg::ADDR_BITS-1:0] paddr;
    logic [wsf_pkg::DATA_BITS-1:0] pwdata;
    logic [wsf_pkg::DATA_BITS-1:0] prdata;
    logic pready;

    wsf_in_if  in_ch ();
    wsf_out_if out_ch ();

    wigner_seitz_fold_core u_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    // Local copy of the lattice, the derived neighbours and the folded vector.
    logic [wsf_pkg::LREG_BITS-1:0] lattice_regs [3];
    longint neighbours [13][3];
    longint half_norm [13];
    longint fold_vec [3];
    longint lattice_span;

    fold_res_t expected_results [$];
    int errors;
    int items_sent;
    int results_seen;
    int folds_sent;
    int gave_up_seen;
    int settings_used;
    int hold_cycles;
    int stall_left;
    bit no_idling;
    int idle_count;

    // Clock.
    initial begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Neighbour vectors and their half norms from the lattice registers.
    function automatic void derive_neighbours();
        longint a [3][3];
        longint s;
        longint sq;
        lattice_span = 0;
        for (int i = 0; i < 3; i++) begin
            for (int c = 0; c < 3; c++) begin
                a[i][c] = longint'($signed(
                    lattice_regs[i][wsf_pkg::LAT_BITS*c +: wsf_pkg::LAT_BITS]));
                if (a[i][c] > lattice_span) lattice_span = a[i][c];
                if (-a[i][c] > lattice_span) lattice_span = -a[i][c];
            end
        end
        for (int j = 0; j < 13; j++) begin
            sq = 0;
            for (int c = 0; c < 3; c++) begin
                s = longint'(wsf_pkg::COMBO[j][0]) * a[0][c]
                    + longint'(wsf_pkg::COMBO[j][1]) * a[1][c]
                    + longint'(wsf_pkg::COMBO[j][2]) * a[2][c];
                neighbours[j][c] = s;
                sq += s * s;
            end
            half_norm[j] = sq;
        end
    endfunction

    // Projection of the folded vector on neighbour j, doubled.
    function automatic longint dot_twice(int j);
        return 2 * (fold_vec[0] * neighbours[j][0] + fold_vec[1] * neighbours[j][1]
                    + fold_vec[2] * neighbours[j][2]);
    endfunction

    function automatic bit lies_in_cell();
        longint d;
        for (int j = 0; j < wsf_pkg::NEIGHBOUR_COUNT && j < 13; j++) begin
            d = dot_twice(j);
            if (d > half_norm[j] || d < -half_norm[j]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic longint saturate(longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    // One scan over the neighbours; stops at the first adjustment.
    function automatic bit fold_scan();
        longint d;
        longint h;
        longint k;
        longint sgn;
        for (int j = 0; j < wsf_pkg::NEIGHBOUR_COUNT && j < 13; j++) begin
            d = dot_twice(j);
            h = half_norm[j];
            if (h > 0 && (d > h || d < -h)) begin
                if (d > h) begin
                    k = (d + h - 1) / (2 * h);
                    sgn = -1;
                end else begin
                    k = (-d + h - 1) / (2 * h);
                    sgn = 1;
                end
                for (int c = 0; c < 3; c++)
                    fold_vec[c] = saturate(fold_vec[c] + sgn * k * neighbours[j][c]);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic fold_res_t predict_fold(logic op, wsf_pkg::coord_t x,
                                               wsf_pkg::coord_t y, wsf_pkg::coord_t z);
        fold_res_t r;
        bit changed;
        fold_vec[0] = longint'(x);
        fold_vec[1] = longint'(y);
        fold_vec[2] = longint'(z);
        r.in_cell = lies_in_cell();
        r.gave_up = 1'b0;
        if (op == OP_FOLD) begin
            changed = 1'b1;
            for (int p = 0; p < wsf_pkg::MAX_PASSES && changed; p++)
                changed = fold_scan();
            r.gave_up = changed;
        end
        r.x = wsf_pkg::coord_t'(fold_vec[0]);
        r.y = wsf_pkg::coord_t'(fold_vec[1]);
        r.z = wsf_pkg::coord_t'(fold_vec[2]);
        return r;
    endfunction

    // Sender gaps: mostly none or short, a few long.
    function automatic int pick_gap();
        int r;
        if (no_idling) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 80);
    endfunction

    // Sends one vector; called and returns at a falling edge.
    task automatic send_vector(input logic op, input wsf_pkg::coord_t x,
                               input wsf_pkg::coord_t y, input wsf_pkg::coord_t z);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.operation = op;
        in_ch.vec_x = x;
        in_ch.vec_y = y;
        in_ch.vec_z = z;
        do @(posedge clk); while (!in_ch.ready);
        expected_results.push_back(predict_fold(op, x, y, z));
        items_sent++;
        if (op == OP_FOLD) folds_sent++;
        @(negedge clk);
    endtask

    // Stops offering and waits until every expected result has arrived.
    task automatic drain();
        in_ch.valid = 1'b0;
        while (expected_results.size() != 0) @(negedge clk);
    endtask

    // APB write of one register; the local model follows valid indexes only.
    task automatic write_lattice(input logic [1:0] idx,
                                 input logic [wsf_pkg::LREG_BITS-1:0] value);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = wsf_pkg::ADDR_BITS'(idx) << 3;
        pwdata = {1'($urandom_range(0, 1)), value};
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        if (idx != REG_UNUSED) begin
            lattice_regs[idx] = value;
            derive_neighbours();
        end
    endtask

    function automatic logic [wsf_pkg::LREG_BITS-1:0] pack_vec(longint x, longint y,
                                                               longint z);
        return {wsf_pkg::LAT_BITS'(z), wsf_pkg::LAT_BITS'(y), wsf_pkg::LAT_BITS'(x)};
    endfunction

    task automatic set_lattice(input logic [wsf_pkg::LREG_BITS-1:0] a0,
                               input logic [wsf_pkg::LREG_BITS-1:0] a1,
                               input logic [wsf_pkg::LREG_BITS-1:0] a2);
        drain();
        write_lattice(wsf_pkg::REG_LATTICE_0, a0);
        write_lattice(wsf_pkg::REG_LATTICE_1, a1);
        write_lattice(wsf_pkg::REG_LATTICE_2, a2);
        settings_used++;
    endtask

    // Coordinate near the current cell, at full range, or at an extreme.
    function automatic wsf_pkg::coord_t pick_coord();
        longint span;
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return wsf_pkg::coord_t'($urandom());
        if (r == 2) begin
            case ($urandom_range(0, 3))
                0: return wsf_pkg::coord_t'(COORD_MAX);
                1: return wsf_pkg::coord_t'(COORD_MIN);
                2: return '0;
                default: return '1;
            endcase
        end
        span = 3 * lattice_span + 4096;
        if (span > COORD_MAX) span = COORD_MAX;
        return wsf_pkg::coord_t'(longint'($urandom_range(0, 32'(2 * span))) - span);
    endfunction

    function automatic longint pick_perturb(longint size);
        return longint'($urandom_range(0, 32'(2 * size))) - size;
    endfunction

    // Near-orthogonal lattice of random scale, or a strongly skewed one.
    function automatic logic [wsf_pkg::LREG_BITS-1:0] pick_axis(int axis, longint size,
                                                                bit skewed);
        longint c [3];
        longint p;
        p = skewed ? size : size / 4;
        for (int i = 0; i < 3; i++) begin
            c[i] = pick_perturb(p);
            if (i == axis) c[i] += ($urandom_range(0, 1) != 0) ? size : -size;
            if (c[i] > LAT_MAX) c[i] = LAT_MAX;
            if (c[i] < LAT_MIN) c[i] = LAT_MIN;
        end
        return pack_vec(c[0], c[1], c[2]);
    endfunction

    // Reset lattice: all neighbours are zero, so every vector stays put.
    task automatic test_zero_lattice();
        send_vector(OP_TEST, '0, '0, '0);
        send_vector(OP_FOLD, wsf_pkg::coord_t'(COORD_MAX), wsf_pkg::coord_t'(COORD_MIN), '1);
        send_vector(OP_TEST, wsf_pkg::coord_t'(COORD_MIN), wsf_pkg::coord_t'(COORD_MAX),
                    wsf_pkg::coord_t'(COORD_MAX));
        // The unused register address must be ignored.
        drain();
        write_lattice(REG_UNUSED, '1);
        send_vector(OP_FOLD, wsf_pkg::coord_t'(123456), wsf_pkg::coord_t'(-98765),
                    wsf_pkg::coord_t'(4096));
    endtask

    // Simple cubic lattice of unit length: boundary, just outside, far away.
    task automatic test_cubic_cell();
        set_lattice(pack_vec(4096, 0, 0), pack_vec(0, 4096, 0), pack_vec(0, 0, 4096));
        send_vector(OP_TEST, wsf_pkg::coord_t'(2048), '0, '0);
        send_vector(OP_FOLD, wsf_pkg::coord_t'(2048), wsf_pkg::coord_t'(-2048),
                    wsf_pkg::coord_t'(2048));
        send_vector(OP_TEST, wsf_pkg::coord_t'(2049), '0, '0);
        send_vector(OP_FOLD, wsf_pkg::coord_t'(2049), '0, '0);
        send_vector(OP_FOLD, wsf_pkg::coord_t'(-2049), wsf_pkg::coord_t'(6000), '0);
        send_vector(OP_FOLD, wsf_pkg::coord_t'(COORD_MAX), wsf_pkg::coord_t'(COORD_MAX),
                    wsf_pkg::coord_t'(COORD_MAX));
        send_vector(OP_FOLD, wsf_pkg::coord_t'(COORD_MIN), wsf_pkg::coord_t'(COORD_MIN),
                    wsf_pkg::coord_t'(COORD_MIN));
        send_vector(OP_TEST, wsf_pkg::coord_t'(COORD_MAX), wsf_pkg::coord_t'(COORD_MIN), '0);
        send_vector(OP_FOLD, wsf_pkg::coord_t'(10000), wsf_pkg::coord_t'(-7000),
                    wsf_pkg::coord_t'(3000));
    endtask

    // Extreme lattice values: full scale axes, an all-max degenerate set and a mixed max/min set.
    task automatic test_extreme_lattice();
        set_lattice(pack_vec(LAT_MAX, 0, 0), pack_vec(0, LAT_MIN, 0), pack_vec(0, 0, LAT_MAX));
        send_vector(OP_FOLD, wsf_pkg::coord_t'(COORD_MAX), wsf_pkg::coord_t'(COORD_MIN),
                    wsf_pkg::coord_t'(COORD_MAX));
        send_vector(OP_TEST, wsf_pkg::coord_t'(524288), wsf_pkg::coord_t'(-524288), '0);
        send_vector(OP_FOLD, wsf_pkg::coord_t'(COORD_MIN), wsf_pkg::coord_t'(1),
                    wsf_pkg::coord_t'(-1));
        set_lattice(pack_vec(LAT_MAX, LAT_MAX, LAT_MAX), pack_vec(LAT_MAX, LAT_MAX, LAT_MAX),
                    pack_vec(LAT_MAX, LAT_MAX, LAT_MAX));
        send_vector(OP_FOLD, wsf_pkg::coord_t'(COORD_MAX), wsf_pkg::coord_t'(COORD_MAX),
                    wsf_pkg::coord_t'(COORD_MAX));
        send_vector(OP_TEST, wsf_pkg::coord_t'(COORD_MIN), '0, wsf_pkg::coord_t'(COORD_MAX));
        set_lattice(pack_vec(LAT_MIN, LAT_MIN, LAT_MIN), pack_vec(LAT_MAX, LAT_MIN, 0),
                    pack_vec(LAT_MIN, LAT_MAX, LAT_MIN));
        send_vector(OP_FOLD, wsf_pkg::coord_t'(COORD_MAX), wsf_pkg::coord_t'(COORD_MIN),
                    wsf_pkg::coord_t'(COORD_MIN));
        send_vector(OP_FOLD, wsf_pkg::coord_t'(COORD_MIN), wsf_pkg::coord_t'(COORD_MAX),
                    wsf_pkg::coord_t'(-5));
    endtask

    // Random lattices with random vectors, mostly folds.
    task automatic test_random_lattices(input int phases, input int per_phase);
        longint size;
        bit skewed;
        logic op;
        for (int p = 0; p < phases; p++) begin
            skewed = (p % 4 == 3);
            size = longint'(1) << $urandom_range(8, 19);
            set_lattice(pick_axis(0, size, skewed), pick_axis(1, size, skewed),
                        pick_axis(2, size, skewed));
            no_idling = (p % 3 == 1);
            for (int i = 0; i < (skewed ? per_phase / 3 : per_phase); i++) begin
                op = ($urandom_range(0, 3) != 0) ? OP_FOLD : OP_TEST;
                send_vector(op, pick_coord(), pick_coord(), pick_coord());
            end
            no_idling = 1'b0;
        end
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering.
    task automatic test_backpressure();
        hold_cycles = 3000;
        for (int i = 0; i < 12; i++)
            send_vector(($urandom_range(0, 1) != 0) ? OP_FOLD : OP_TEST,
                        pick_coord(), pick_coord(), pick_coord());
    endtask

    // Result side ready: random stalls unless a hold or a no-idle stretch is on.
    initial begin
        out_ch.ready = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge clk);
            if (hold_cycles > 0) begin
                out_ch.ready = 1'b0;
                hold_cycles--;
            end else if (stall_left > 0) begin
                out_ch.ready = 1'b0;
                stall_left--;
            end else if (!no_idling && $urandom_range(0, 3) == 0) begin
                out_ch.ready = 1'b0;
                stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
                                                           : $urandom_range(0, 3);
            end else begin
                out_ch.ready = 1'b1;
            end
        end
    end

    // Compares each result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        fold_res_t exp_r;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            results_seen++;
            if (out_ch.gave_up === 1'b1) gave_up_seen++;
            if (expected_results.size() == 0) begin
                $error("result transfer with no expectation waiting");
                errors++;
            end else begin
                exp_r = expected_results.pop_front();
                if (out_ch.out_x !== exp_r.x) begin
                    $error("out_x: expected %0d, got %0d", exp_r.x, out_ch.out_x);
                    errors++;
                end
                if (out_ch.out_y !== exp_r.y) begin
                    $error("out_y: expected %0d, got %0d", exp_r.y, out_ch.out_y);
                    errors++;
                end
                if (out_ch.out_z !== exp_r.z) begin
                    $error("out_z: expected %0d, got %0d", exp_r.z, out_ch.out_z);
                    errors++;
                end
                if (out_ch.was_inside !== exp_r.in_cell) begin
                    $error("was_inside: expected %0b, got %0b", exp_r.in_cell,
                           out_ch.was_inside);
                    errors++;
                end
                if (out_ch.gave_up !== exp_r.gave_up) begin
                    $error("gave_up: expected %0b, got %0b", exp_r.gave_up, out_ch.gave_up);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= IDLE_LIMIT) begin
            $display("timeout after %0d cycles without a transfer", IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Main sequence.
    initial begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.operation = OP_TEST;
        in_ch.vec_x = '0;
        in_ch.vec_y = '0;
        in_ch.vec_z = '0;
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        folds_sent = 0;
        gave_up_seen = 0;
        settings_used = 1;
        hold_cycles = 0;
        no_idling = 1'b0;
        idle_count = 0;
        for (int i = 0; i < 3; i++) lattice_regs[i] = '0;
        derive_neighbours();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_zero_lattice();
        test_cubic_cell();
        test_extreme_lattice();
        test_random_lattices(8, 100);
        test_backpressure();
        test_random_lattices(1, 40);

        drain();
        repeat (200) @(negedge clk);
        $display("Sent %0d vectors (%0d folds) over %0d lattice settings.",
                 items_sent, folds_sent, settings_used);
        $display("Checked %0d results, %0d of them with the pass cap reached.",
                 results_seen, gave_up_seen);
        if (errors == 0 && expected_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
